>>> rtl/core/mt_sfd_pkg.sv
// Package with the types, codes and reset constants of the serial frame deframer.
`timescale 1ns / 1ps

package mt_sfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STATUS_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SRSP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_AREQ   = 2'd3;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'hFE;
    localparam logic [BYTE_W-1:0] RST_TYPE_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] RST_TYPE_SRSP  = 8'h60;
    localparam logic [BYTE_W-1:0] RST_TYPE_AREQ  = 8'h40;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_CMD0    = 3'd2,
        PH_CMD1    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD     = 2'd0,
        ST_BADCHECK = 2'd1,
        ST_BADTYPE  = 2'd2
    } t_status;

endpackage

>>> rtl/core/mt_sfd_in_if.sv
// Interface of the received byte channel of the serial frame deframer.
`timescale 1ns / 1ps

interface mt_sfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [mt_sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/mt_sfd_out_if.sv
// Interface of the result channel of the serial frame deframer.
`timescale 1ns / 1ps

interface mt_sfd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            result_kind;
    logic [mt_sfd_pkg::BYTE_W-1:0]   data_byte;
    logic [mt_sfd_pkg::BYTE_W-1:0]   byte_index;
    logic [mt_sfd_pkg::BYTE_W-1:0]   frame_length;
    logic [mt_sfd_pkg::BYTE_W-1:0]   first_command;
    logic [mt_sfd_pkg::BYTE_W-1:0]   second_command;
    logic [mt_sfd_pkg::STATUS_W-1:0] frame_status;

    modport source (
        output valid, output result_kind, output data_byte, output byte_index,
        output frame_length, output first_command, output second_command,
        output frame_status, input ready
    );
    modport sink (
        input valid, input result_kind, input data_byte, input byte_index,
        input frame_length, input first_command, input second_command,
        input frame_status, output ready
    );
endinterface

>>> rtl/core/mt_serial_frame_deframer_top.sv
// Top level of the serial frame deframer with XOR frame check.
// A result word is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one received word per cycle; the frame phase update and one XOR are combinational.
// The only stall comes from a full output register whose word the sink does not take.
// Reset (i_rst_n, synchronous, active low) returns to hunting, clears the held header,
// check and count, empties the output register and restores the configuration defaults.
`timescale 1ns / 1ps

module mt_serial_frame_deframer_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mt_sfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mt_sfd_pkg::BYTE_W-1:0]          i_cfg_data,
    mt_sfd_in_if.sink                              i_rx,
    mt_sfd_out_if.source                           o_res
);

    // Configuration registers.
    logic [mt_sfd_pkg::BYTE_W-1:0] r_start_byte;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_type_mask;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_type_srsp;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_type_areq;

    // Frame state.
    mt_sfd_pkg::t_phase            r_phase, n_phase;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_length, n_length;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_cmd0, n_cmd0;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_cmd1, n_cmd1;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_check, n_check;
    logic [mt_sfd_pkg::BYTE_W-1:0] r_count, n_count;

    // Output register. The payload carries no reset; only the valid flag does.
    logic                            r_out_valid, n_out_valid;
    logic                            r_kind, n_kind;
    logic [mt_sfd_pkg::BYTE_W-1:0]   r_data, n_data;
    logic [mt_sfd_pkg::BYTE_W-1:0]   r_index, n_index;
    logic [mt_sfd_pkg::BYTE_W-1:0]   r_flen, n_flen;
    logic [mt_sfd_pkg::BYTE_W-1:0]   r_fcmd0, n_fcmd0;
    logic [mt_sfd_pkg::BYTE_W-1:0]   r_fcmd1, n_fcmd1;
    logic [mt_sfd_pkg::STATUS_W-1:0] r_status, n_status;

    logic                          w_accept;
    logic                          w_emit;
    logic [mt_sfd_pkg::BYTE_W-1:0] w_byte;
    logic [mt_sfd_pkg::BYTE_W-1:0] w_type;
    logic [mt_sfd_pkg::BYTE_W-1:0] w_count_inc;

    // A new word may enter whenever the output register is empty or is being
    // emptied in this cycle, so the two sides run back to back.
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign w_byte      = i_rx.rx_byte;
    assign w_type      = r_cmd0 & r_type_mask;
    assign w_count_inc = r_count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= mt_sfd_pkg::RST_START_BYTE;
            r_type_mask  <= mt_sfd_pkg::RST_TYPE_MASK;
            r_type_srsp  <= mt_sfd_pkg::RST_TYPE_SRSP;
            r_type_areq  <= mt_sfd_pkg::RST_TYPE_AREQ;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mt_sfd_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data;
                mt_sfd_pkg::CFG_TYPE_MASK:  r_type_mask  <= i_cfg_data;
                mt_sfd_pkg::CFG_TYPE_SRSP:  r_type_srsp  <= i_cfg_data;
                mt_sfd_pkg::CFG_TYPE_AREQ:  r_type_areq  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Phase sequencing, check accumulation and result formation for one word.
    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_cmd0   = r_cmd0;
        n_cmd1   = r_cmd1;
        n_check  = r_check;
        n_count  = r_count;
        w_emit   = 1'b0;
        n_kind   = r_kind;
        n_data   = r_data;
        n_index  = r_index;
        n_flen   = r_flen;
        n_fcmd0  = r_fcmd0;
        n_fcmd1  = r_fcmd1;
        n_status = r_status;

        if (w_accept) begin
            case (r_phase)
                mt_sfd_pkg::PH_LENGTH: begin
                    n_length = w_byte;
                    n_check  = w_byte;
                    n_count  = '0;
                    n_phase  = mt_sfd_pkg::PH_CMD0;
                end
                mt_sfd_pkg::PH_CMD0: begin
                    n_cmd0  = w_byte;
                    n_check = r_check ^ w_byte;
                    n_phase = mt_sfd_pkg::PH_CMD1;
                end
                mt_sfd_pkg::PH_CMD1: begin
                    n_cmd1  = w_byte;
                    n_check = r_check ^ w_byte;
                    // An empty frame goes straight on to its check byte.
                    n_phase = (r_length == '0) ? mt_sfd_pkg::PH_CHECK
                                               : mt_sfd_pkg::PH_PAYLOAD;
                end
                mt_sfd_pkg::PH_PAYLOAD: begin
                    n_check  = r_check ^ w_byte;
                    w_emit   = 1'b1;
                    n_kind   = mt_sfd_pkg::KIND_PAYLOAD;
                    n_data   = w_byte;
                    n_index  = r_count;
                    n_flen   = '0;
                    n_fcmd0  = '0;
                    n_fcmd1  = '0;
                    n_status = mt_sfd_pkg::ST_GOOD;
                    n_count  = w_count_inc;
                    if (w_count_inc == r_length) begin
                        n_phase = mt_sfd_pkg::PH_CHECK;
                    end
                end
                mt_sfd_pkg::PH_CHECK: begin
                    w_emit  = 1'b1;
                    n_kind  = mt_sfd_pkg::KIND_END;
                    n_data  = '0;
                    n_index = '0;
                    n_flen  = r_length;
                    n_fcmd0 = r_cmd0;
                    n_fcmd1 = r_cmd1;
                    // A check mismatch outranks an unaccepted command type.
                    if (r_check != w_byte) begin
                        n_status = mt_sfd_pkg::ST_BADCHECK;
                    end else if (w_type == r_type_srsp || w_type == r_type_areq) begin
                        n_status = mt_sfd_pkg::ST_GOOD;
                    end else begin
                        n_status = mt_sfd_pkg::ST_BADTYPE;
                    end
                    n_phase = mt_sfd_pkg::PH_HUNT;
                end
                default: begin
                    // Hunting: anything but the start byte is dropped.
                    n_phase = (w_byte == r_start_byte) ? mt_sfd_pkg::PH_LENGTH
                                                       : mt_sfd_pkg::PH_HUNT;
                end
            endcase
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mt_sfd_pkg::PH_HUNT;
            r_length    <= '0;
            r_cmd0      <= '0;
            r_cmd1      <= '0;
            r_check     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_cmd0      <= n_cmd0;
            r_cmd1      <= n_cmd1;
            r_check     <= n_check;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_index  <= n_index;
        r_flen   <= n_flen;
        r_fcmd0  <= n_fcmd0;
        r_fcmd1  <= n_fcmd1;
        r_status <= n_status;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_kind;
    assign o_res.data_byte      = r_data;
    assign o_res.byte_index     = r_index;
    assign o_res.frame_length   = r_flen;
    assign o_res.first_command  = r_fcmd0;
    assign o_res.second_command = r_fcmd1;
    assign o_res.frame_status   = r_status;

endmodule

>>> bench/mt_sfd_scoreboard_pkg.sv
// Scoreboard class with a frame predictor for the serial frame deframer bench.
`timescale 1ns / 1ps

package mt_sfd_scoreboard_pkg;

    import mt_sfd_pkg::*;

    typedef struct {
        logic                result_kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [BYTE_W-1:0]   byte_index;
        logic [BYTE_W-1:0]   frame_length;
        logic [BYTE_W-1:0]   first_command;
        logic [BYTE_W-1:0]   second_command;
        logic [STATUS_W-1:0] frame_status;
    } t_result_word;

    class frame_scoreboard;

        // Register copies.
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] type_mask;
        logic [BYTE_W-1:0] type_srsp;
        logic [BYTE_W-1:0] type_areq;

        // Frame state as the block should hold it.
        t_phase            phase;
        logic [BYTE_W-1:0] held_length;
        logic [BYTE_W-1:0] held_cmd0;
        logic [BYTE_W-1:0] held_cmd1;
        logic [BYTE_W-1:0] running_xor;
        logic [BYTE_W-1:0] payload_pos;

        t_result_word expected_words[$];
        int unsigned  errors;
        int unsigned  payload_words;
        int unsigned  status_count[3];

        function new();
            start_byte    = RST_START_BYTE;
            type_mask     = RST_TYPE_MASK;
            type_srsp     = RST_TYPE_SRSP;
            type_areq     = RST_TYPE_AREQ;
            phase         = PH_HUNT;
            held_length   = '0;
            held_cmd0     = '0;
            held_cmd1     = '0;
            running_xor   = '0;
            payload_pos   = '0;
            errors        = 0;
            payload_words = 0;
            status_count  = '{0, 0, 0};
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
            case (index)
                CFG_START_BYTE: start_byte = value;
                CFG_TYPE_MASK:  type_mask  = value;
                CFG_TYPE_SRSP:  type_srsp  = value;
                CFG_TYPE_AREQ:  type_areq  = value;
                default: ;
            endcase
        endfunction

        // Advances the frame state by one accepted byte and queues any word it causes.
        function void note_byte(logic [BYTE_W-1:0] rx);
            t_result_word      w;
            t_status           status;
            logic [BYTE_W-1:0] cmd_type;
            w = '{default: '0};
            case (phase)
                PH_LENGTH: begin
                    held_length = rx;
                    running_xor = rx;
                    payload_pos = '0;
                    phase       = PH_CMD0;
                end
                PH_CMD0: begin
                    held_cmd0   = rx;
                    running_xor = running_xor ^ rx;
                    phase       = PH_CMD1;
                end
                PH_CMD1: begin
                    held_cmd1   = rx;
                    running_xor = running_xor ^ rx;
                    phase       = (held_length == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    running_xor   = running_xor ^ rx;
                    w.result_kind = KIND_PAYLOAD;
                    w.data_byte   = rx;
                    w.byte_index  = payload_pos;
                    expected_words.push_back(w);
                    payload_pos = payload_pos + 1'b1;
                    if (payload_pos == held_length) begin
                        phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    cmd_type = held_cmd0 & type_mask;
                    if (running_xor != rx) begin
                        status = ST_BADCHECK;
                    end else if (cmd_type == type_srsp || cmd_type == type_areq) begin
                        status = ST_GOOD;
                    end else begin
                        status = ST_BADTYPE;
                    end
                    w.result_kind    = KIND_END;
                    w.frame_length   = held_length;
                    w.first_command  = held_cmd0;
                    w.second_command = held_cmd1;
                    w.frame_status   = status;
                    expected_words.push_back(w);
                    phase = PH_HUNT;
                end
                default: begin
                    if (rx == start_byte) begin
                        phase = PH_LENGTH;
                    end
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_word(t_result_word got);
            t_result_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word kind=%h data=%h idx=%h len=%h c0=%h c1=%h st=%h",
                                 got.result_kind, got.data_byte, got.byte_index,
                                 got.frame_length, got.first_command, got.second_command,
                                 got.frame_status));
            end else begin
                want = expected_words.pop_front();
                if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
                    got.byte_index !== want.byte_index ||
                    got.frame_length !== want.frame_length ||
                    got.first_command !== want.first_command ||
                    got.second_command !== want.second_command ||
                    got.frame_status !== want.frame_status) begin
                    report($sformatf({"got kind=%h data=%h idx=%h len=%h c0=%h c1=%h st=%h, ",
                                      "want %h %h %h %h %h %h %h"},
                                     got.result_kind, got.data_byte, got.byte_index,
                                     got.frame_length, got.first_command,
                                     got.second_command, got.frame_status,
                                     want.result_kind, want.data_byte, want.byte_index,
                                     want.frame_length, want.first_command,
                                     want.second_command, want.frame_status));
                end else if (want.result_kind == KIND_END) begin
                    status_count[want.frame_status]++;
                end else begin
                    payload_words++;
                end
            end
        endtask

        function int unsigned pending();
            return expected_words.size();
        endfunction

    endclass

endpackage

>>> bench/mt_serial_frame_deframer_top_tb.sv
// Self-checking bench for the serial frame deframer top level.
`timescale 1ns / 1ps

module mt_serial_frame_deframer_top_tb;

    import mt_sfd_pkg::*;
    import mt_sfd_scoreboard_pkg::*;

    // Quiet cycles tolerated before the run is declared hung. The longest quiet
    // stretch of a healthy run is the settling and register writes plus a run of
    // sender idles or receiver stalls, so this is far beyond anything a working block needs.
    localparam int unsigned QUIET_LIMIT   = 2000;
    // The block answers in the cycle after it takes a byte; this settling time covers it.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CHUNK_BYTES   = 120;
    localparam int unsigned CHUNKS        = 6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    mt_sfd_in_if  rx_if ();
    mt_sfd_out_if res_if ();

    mt_serial_frame_deframer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    frame_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     bytes_sent;
    int unsigned     quiet_cycles;

    // Opening directed sequence, run with the reset register values. It starts
    // with two stray bytes that must be dropped while hunting, then gives an
    // empty good frame, a one-byte frame whose payload is itself the start
    // value, a frame with both a bad check and a refused type (the check must
    // win), a frame whose only fault is its type, and one whose only fault is
    // its check byte.
    logic [BYTE_W-1:0] opening_bytes [] = '{
        8'h00, 8'hFF,
        RST_START_BYTE, 8'h00, 8'h60, 8'h5A, 8'h3A,
        RST_START_BYTE, 8'h01, 8'h5F, 8'hFF, RST_START_BYTE, 8'h5F,
        RST_START_BYTE, 8'h00, 8'h20, 8'h00, 8'h21,
        RST_START_BYTE, 8'h00, 8'hE0, 8'h00, 8'hE0,
        RST_START_BYTE, 8'h00, 8'h40, 8'h00, 8'h41
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random according to the current idling mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both channels are sampled at the clock edge, so the values seen are the
    // ones the block itself acts on. The watchdog counts edges at which no
    // word moves on either channel.
    always @(posedge i_clk) begin : monitor
        t_result_word got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                sb.note_byte(rx_if.rx_byte);
            end
            if (res_if.valid && res_if.ready) begin
                got.result_kind    = res_if.result_kind;
                got.data_byte      = res_if.data_byte;
                got.byte_index     = res_if.byte_index;
                got.frame_length   = res_if.frame_length;
                got.first_command  = res_if.first_command;
                got.second_command = res_if.second_command;
                got.frame_status   = res_if.frame_status;
                sb.check_word(got);
            end
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] Watchdog expired with %0d words outstanding",
                         $time, sb.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offers one byte, with a random number of idle cycles first, and returns
    // at the edge where the block takes it. Valid stays high for a following
    // byte unless that byte chooses to idle first.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        @(posedge i_clk);
        while (!rx_if.ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // Holds the sender back until every predicted word has come out, then
    // lets the block settle. The first edge makes sure the monitor has seen
    // the last byte before the queue is looked at.
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges while the block is idle.
    task automatic load_settings(input logic [BYTE_W-1:0] start_val,
                                 input logic [BYTE_W-1:0] mask_val,
                                 input logic [BYTE_W-1:0] srsp_val,
                                 input logic [BYTE_W-1:0] areq_val);
        logic [CFG_IDX_W-1:0] reg_index [4];
        logic [BYTE_W-1:0]    reg_value [4];
        reg_index = '{CFG_START_BYTE, CFG_TYPE_MASK, CFG_TYPE_SRSP, CFG_TYPE_AREQ};
        reg_value = '{start_val, mask_val, srsp_val, areq_val};
        drain_results();
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data  <= reg_value[k];
            @(posedge i_clk);
            sb.set_register(reg_index[k], reg_value[k]);
        end
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds one frame with a random payload and sends it. A nonzero
    // check_flip spoils the check byte; a nonzero cut sends only that many
    // bytes, so the frame runs on into whatever follows.
    task automatic send_frame(input int unsigned       len,
                              input logic [BYTE_W-1:0] cmd0,
                              input logic [BYTE_W-1:0] cmd1,
                              input logic [BYTE_W-1:0] check_flip,
                              input int unsigned       cut);
        logic [BYTE_W-1:0] frame_bytes [$];
        logic [BYTE_W-1:0] fcs;
        logic [BYTE_W-1:0] pay;
        int unsigned       count;
        frame_bytes = {sb.start_byte, BYTE_W'(len), cmd0, cmd1};
        fcs = BYTE_W'(len) ^ cmd0 ^ cmd1;
        repeat (len) begin
            // The start value turns up inside payloads now and then, where it
            // must be taken as plain data.
            pay = ($urandom_range(15) == 0) ? sb.start_byte : BYTE_W'($urandom);
            fcs = fcs ^ pay;
            frame_bytes.push_back(pay);
        end
        frame_bytes.push_back(fcs ^ check_flip);
        count = (cut != 0) ? cut : frame_bytes.size();
        for (int k = 0; k < count; k++) begin
            send_byte(frame_bytes[k]);
        end
    endtask

    // Random traffic: mostly whole frames with random content, some with a
    // spoiled check, plus stray bytes and frames that are cut short. Lengths
    // are mostly small; now and then one runs up to the full byte range.
    task automatic run_chunk(input int unsigned chunk_bytes, input bit with_longest);
        int unsigned       target;
        int unsigned       pick;
        int unsigned       len;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] cmd0;
        target = bytes_sent + chunk_bytes;
        if (with_longest) begin
            send_frame(255, (sb.type_srsp & sb.type_mask), BYTE_W'($urandom), '0, 0);
        end
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(12);
            code = $urandom_range(1) ? sb.type_srsp : sb.type_areq;
            // Most first command bytes carry one of the accepted type codes
            // under the current mask, so that good frames are common.
            cmd0 = ($urandom_range(9) < 7) ?
                   ((code & sb.type_mask) | (BYTE_W'($urandom) & ~sb.type_mask)) :
                   BYTE_W'($urandom);
            if (pick < 10) begin
                send_byte(BYTE_W'($urandom));
            end else if (pick < 20) begin
                send_frame(len, cmd0, BYTE_W'($urandom), '0, $urandom_range(len + 4, 1));
            end else begin
                send_frame(len, cmd0, BYTE_W'($urandom),
                           ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(255, 1)) : '0, 0);
            end
        end
        // Stray bytes or a cut frame may leave a frame open. Filler bytes
        // close it so that the registers are only changed while hunting. The
        // idle edge after each byte lets the monitor update the phase first.
        drain_results();
        while (sb.phase != PH_HUNT) begin
            send_byte(BYTE_W'($urandom));
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 65;
        bytes_sent    = 0;
        quiet_cycles  = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_bytes[k]) begin
            send_byte(opening_bytes[k]);
        end

        // Six random chunks: two per idling mode, each under its own register
        // setting, with the extremes of start value and mask among them. The
        // last chunk goes back to the reset values and carries a frame of the
        // greatest length.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk)
                0: load_settings(8'h00, 8'hFF, 8'hFF, 8'h00);
                1: load_settings(8'hFF, 8'h00, 8'h00, 8'hFF);
                3: load_settings(8'h7E, 8'h0F, 8'h05, 8'h0A);
                5: load_settings(RST_START_BYTE, RST_TYPE_MASK, RST_TYPE_SRSP, RST_TYPE_AREQ);
                default: load_settings(BYTE_W'($urandom), BYTE_W'($urandom),
                                       BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            if (chunk < 2) begin
                send_idle_pct = 19;
                recv_idle_pct = 65;
            end else if (chunk < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_chunk(CHUNK_BYTES, chunk == CHUNKS - 1);
        end

        drain_results();

        $display("Run covered %0d received words over six register settings %s",
                 bytes_sent, "and three idling modes;");
        $display("%0d payload words checked, end records: %0d good, %0d bad check, %0d bad type.",
                 sb.payload_words, sb.status_count[ST_GOOD], sb.status_count[ST_BADCHECK],
                 sb.status_count[ST_BADTYPE]);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
